@@ hdl/ptrs_pkg.sv @@
// Shared op codes and controller/datapath interface types for the task release scheduler.
`timescale 1ns / 1ps

package ptrs_pkg;

  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_DISPATCH   = 3'd1;
  localparam logic [2:0] OP_ADD        = 3'd2;
  localparam logic [2:0] OP_ENABLE     = 3'd3;
  localparam logic [2:0] OP_SET_PERIOD = 3'd4;
  localparam logic [2:0] OP_RELEASE    = 3'd5;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture input word, clear scan state
    logic step;   // process one slot (or the single addressed slot)
    logic post;   // copy result into the output register
  } ptrs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;   // the current step is the last one for this word
  } ptrs_sts_t;

endpackage

@@ hdl/ptrs_ctrl.sv @@
// Sequencing state machine: accepts a word, steps the datapath, posts the result.
`timescale 1ns / 1ps

module ptrs_ctrl
  import ptrs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ptrs_cmd_t cmd,
  input  ptrs_sts_t sts
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_POST
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (sts.done) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        // output register free, or being emptied this cycle
        if (!out_valid_r || out_ready) begin
          cmd.post      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |-> (!out_valid_r || out_ready))
    else $error("result posted over an unread word");

  a_post_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |=> out_valid_r)
    else $error("posted result not presented");

  a_accept_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_RUN))
    else $error("accepted word not processed");

endmodule

@@ hdl/ptrs_dp.sv @@
// Datapath: task slot table, tick counter, per-slot update logic and output register.
`timescale 1ns / 1ps

module ptrs_dp
  import ptrs_pkg::*;
#(
  parameter int TASK_SLOTS   = 8,
  parameter int PENDING_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ptrs_cmd_t   cmd,
  output ptrs_sts_t   sts,
  input  logic [2:0]  in_op,
  input  logic [3:0]  in_slot,
  input  logic [15:0] in_period,
  input  logic        in_enable_flag,
  input  logic        in_release_now,
  output logic        out_accepted,
  output logic        out_dispatched,
  output logic [3:0]  out_task_slot,
  output logic [31:0] out_tick_total
);

  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [SW-1:0] LAST = SW'(TASK_SLOTS - 1);
  localparam logic [4:0] SLOTS5 = 5'(TASK_SLOTS);

  logic                    present_r [TASK_SLOTS];
  logic                    enabled_r [TASK_SLOTS];
  logic [15:0]             period_r  [TASK_SLOTS];
  logic [15:0]             cd_r      [TASK_SLOTS];
  logic [PENDING_BITS-1:0] pend_r    [TASK_SLOTS];

  logic [2:0]  op_r;
  logic [3:0]  slot_r;
  logic [15:0] per_r;
  logic        en_r, rel_r;
  logic [SW-1:0] idx_r, idx_nxt;
  logic        acc_r, acc_nxt;
  logic        disp_r, disp_nxt;
  logic [3:0]  which_r, which_nxt;
  logic [31:0] tick_r, tick_nxt;

  logic        is_scan, slot_ok, sel_ok;
  logic [SW-1:0] sel;
  logic        cur_pres, cur_en;
  logic [15:0] cur_per, cur_cd;
  logic [PENDING_BITS-1:0] cur_pend, pend_inc;
  logic        wr;
  logic        pres_nxt, en_nxt;
  logic [15:0] per_nxt, cd_nxt;
  logic [PENDING_BITS-1:0] pend_nxt;
  logic        hit;

  assign is_scan = (op_r == OP_TICK) || (op_r == OP_DISPATCH);
  assign slot_ok = ({1'b0, slot_r} < SLOTS5);
  assign sel     = is_scan ? idx_r : slot_r[SW-1:0];
  assign sel_ok  = is_scan || slot_ok;

  always_comb begin
    cur_pres = 1'b0;
    cur_en   = 1'b0;
    cur_per  = '0;
    cur_cd   = '0;
    cur_pend = '0;
    if (sel_ok) begin
      cur_pres = present_r[sel];
      cur_en   = enabled_r[sel];
      cur_per  = period_r[sel];
      cur_cd   = cd_r[sel];
      cur_pend = pend_r[sel];
    end
  end

  // saturating +1
  assign pend_inc = (&cur_pend) ? cur_pend : cur_pend + 1'b1;
  assign hit      = cur_pres && cur_en && (cur_pend != '0);

  always_comb begin
    wr        = 1'b0;
    pres_nxt  = cur_pres;
    en_nxt    = cur_en;
    per_nxt   = cur_per;
    cd_nxt    = cur_cd;
    pend_nxt  = cur_pend;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    disp_nxt  = disp_r;
    which_nxt = which_r;
    tick_nxt  = tick_r;
    if (cmd.load) begin
      idx_nxt   = '0;
      acc_nxt   = 1'b0;
      disp_nxt  = 1'b0;
      which_nxt = '0;
      if (in_op == OP_TICK) begin
        tick_nxt = tick_r + 32'd1;
      end
    end else if (cmd.step) begin
      idx_nxt = idx_r + 1'b1;
      unique case (op_r)
        OP_TICK: begin
          acc_nxt = 1'b1;
          if (cur_pres && cur_en && (cur_cd != '0)) begin
            wr = 1'b1;
            if (cur_cd == 16'd1) begin
              cd_nxt   = cur_per;
              pend_nxt = pend_inc;
            end else begin
              cd_nxt = cur_cd - 16'd1;
            end
          end
        end
        OP_DISPATCH: begin
          acc_nxt = 1'b1;
          if (hit) begin
            wr        = 1'b1;
            pend_nxt  = cur_pend - 1'b1;
            disp_nxt  = 1'b1;
            which_nxt = 4'(idx_r);
          end
        end
        OP_ADD: begin
          if (slot_ok) begin
            wr       = 1'b1;
            pres_nxt = 1'b1;
            en_nxt   = 1'b1;
            per_nxt  = per_r;
            cd_nxt   = per_r;
            pend_nxt = PENDING_BITS'(1);
            acc_nxt  = 1'b1;
          end
        end
        OP_ENABLE: begin
          if (slot_ok) begin
            wr      = 1'b1;
            en_nxt  = en_r;
            acc_nxt = 1'b1;
          end
        end
        OP_SET_PERIOD: begin
          if (slot_ok) begin
            wr      = 1'b1;
            per_nxt = per_r;
            cd_nxt  = per_r;
            if (rel_r) begin
              pend_nxt = pend_inc;
            end
            acc_nxt = 1'b1;
          end
        end
        OP_RELEASE: begin
          if (slot_ok && cur_pres) begin
            wr       = 1'b1;
            pend_nxt = pend_inc;
            acc_nxt  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // dispatch stops at the first ready slot
  assign sts.done = !is_scan || (idx_r == LAST) || ((op_r == OP_DISPATCH) && hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        present_r[i] <= 1'b0;
        enabled_r[i] <= 1'b0;
        period_r[i]  <= '0;
        cd_r[i]      <= '0;
        pend_r[i]    <= '0;
      end
      op_r    <= OP_TICK;
      idx_r   <= '0;
      acc_r   <= 1'b0;
      disp_r  <= 1'b0;
      which_r <= '0;
      tick_r  <= '0;
    end else begin
      if (wr) begin
        present_r[sel] <= pres_nxt;
        enabled_r[sel] <= en_nxt;
        period_r[sel]  <= per_nxt;
        cd_r[sel]      <= cd_nxt;
        pend_r[sel]    <= pend_nxt;
      end
      if (cmd.load) begin
        op_r <= in_op;
      end
      idx_r   <= idx_nxt;
      acc_r   <= acc_nxt;
      disp_r  <= disp_nxt;
      which_r <= which_nxt;
      tick_r  <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_r <= in_slot;
      per_r  <= in_period;
      en_r   <= in_enable_flag;
      rel_r  <= in_release_now;
    end
    if (cmd.post) begin
      out_accepted   <= acc_r;
      out_dispatched <= disp_r;
      out_task_slot  <= which_r;
      out_tick_total <= tick_r;
    end
  end

  a_disp_op: assert property (@(posedge clk) disable iff (!rst_n)
    disp_r |-> (op_r == OP_DISPATCH))
    else $error("dispatch flag set on another op");

  a_no_write_bad_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !is_scan) |-> slot_ok)
    else $error("table write to an out-of-range slot");

endmodule

@@ hdl/periodic_task_release_scheduler_top.sv @@
// Top level of the periodic task release scheduler: controller plus datapath.
`timescale 1ns / 1ps

// Periodic task release scheduler. Each word carries one command (tick, dispatch,
// add, enable, set period, release) and yields exactly one result word. Slot index
// is priority, 0 highest. One word is processed at a time: tick and dispatch walk
// the slot table one slot per clock (a dispatch stops early at the first ready
// slot); every other command works on its single addressed slot. A new word is
// accepted while the previous result still waits in the output register. Pending
// release counts saturate at 2^PENDING_BITS - 1.
module periodic_task_release_scheduler_top
  import ptrs_pkg::*;
#(
  parameter int TASK_SLOTS   = 8,
  parameter int PENDING_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [3:0]  in_slot,
  input  logic [15:0] in_period,
  input  logic        in_enable_flag,
  input  logic        in_release_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_dispatched,
  output logic [3:0]  out_task_slot,
  output logic [31:0] out_tick_total
);

  ptrs_cmd_t cmd;
  ptrs_sts_t sts;

  ptrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ptrs_dp #(
    .TASK_SLOTS   (TASK_SLOTS),
    .PENDING_BITS (PENDING_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_slot        (in_slot),
    .in_period      (in_period),
    .in_enable_flag (in_enable_flag),
    .in_release_now (in_release_now),
    .out_accepted   (out_accepted),
    .out_dispatched (out_dispatched),
    .out_task_slot  (out_task_slot),
    .out_tick_total (out_tick_total)
  );

endmodule

@@ verif/ptrs_reply_checker.sv @@
// Reply checker for the task release scheduler: predicts every reply word and compares.
`timescale 1ns / 1ps

module ptrs_reply_checker
  import ptrs_pkg::*;
#(
  parameter int TASK_SLOTS   = 8,
  parameter int PENDING_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [3:0]  in_slot,
  input  logic [15:0] in_period,
  input  logic        in_enable_flag,
  input  logic        in_release_now,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_accepted,
  input  logic        out_dispatched,
  input  logic [3:0]  out_task_slot,
  input  logic [31:0] out_tick_total,
  output int          fail_count,
  output int          replies_outstanding
);

  localparam logic [PENDING_BITS-1:0] PENDING_MAX = '1;

  typedef struct packed {
    logic        accepted;
    logic        dispatched;
    logic [3:0]  task_slot;
    logic [31:0] tick_total;
  } sched_reply_t;

  logic                    slot_present [TASK_SLOTS];
  logic                    slot_enabled [TASK_SLOTS];
  logic [15:0]             slot_period  [TASK_SLOTS];
  logic [15:0]             slot_count   [TASK_SLOTS];
  logic [PENDING_BITS-1:0] slot_pending [TASK_SLOTS];
  logic [31:0]             ticks_seen;
  sched_reply_t            awaited_replies [$];
  int                      errors = 0;

  assign fail_count = errors;

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: reply word mismatch on %s: got %0h, want %0h", $time, field, got, want);
    errors++;
  endtask

  function automatic void bump_pending(int s);
    if (slot_pending[s] != PENDING_MAX) slot_pending[s] = slot_pending[s] + 1'b1;
  endfunction

  // Applies one command word to the shadow slot table and returns the reply it should produce.
  function automatic sched_reply_t schedule_command(logic [2:0] op, logic [3:0] slot,
      logic [15:0] period, logic en, logic rel);
    sched_reply_t r;
    bit           in_range;
    bit           found;
    r = '0;
    in_range = slot < TASK_SLOTS;
    found = 1'b0;
    case (op)
      OP_TICK: begin
        ticks_seen = ticks_seen + 1'b1;
        for (int s = 0; s < TASK_SLOTS; s++) begin
          if (slot_present[s] && slot_enabled[s] && slot_count[s] != '0) begin
            slot_count[s] = slot_count[s] - 1'b1;
            if (slot_count[s] == '0) begin
              bump_pending(s);
              slot_count[s] = slot_period[s];
            end
          end
        end
        r.accepted = 1'b1;
      end
      OP_DISPATCH: begin
        r.accepted = 1'b1;
        // lowest index wins
        for (int s = 0; s < TASK_SLOTS; s++) begin
          if (!found && slot_present[s] && slot_enabled[s] && slot_pending[s] != '0) begin
            slot_pending[s] = slot_pending[s] - 1'b1;
            found = 1'b1;
            r.dispatched = 1'b1;
            r.task_slot = 4'(s);
          end
        end
      end
      OP_ADD: begin
        if (in_range) begin
          slot_present[slot] = 1'b1;
          slot_enabled[slot] = 1'b1;
          slot_period[slot] = period;
          slot_count[slot] = period;
          slot_pending[slot] = PENDING_BITS'(1);
          r.accepted = 1'b1;
        end
      end
      OP_ENABLE: begin
        if (in_range) begin
          slot_enabled[slot] = en;
          r.accepted = 1'b1;
        end
      end
      OP_SET_PERIOD: begin
        if (in_range) begin
          slot_period[slot] = period;
          slot_count[slot] = period;
          if (rel) bump_pending(int'(slot));
          r.accepted = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (in_range) begin
          if (slot_present[slot]) begin
            bump_pending(int'(slot));
            r.accepted = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.tick_total = ticks_seen;
    return r;
  endfunction

  always @(posedge clk) begin
    sched_reply_t want;
    if (!rst_n) begin
      for (int s = 0; s < TASK_SLOTS; s++) begin
        slot_present[s] = 1'b0;
        slot_enabled[s] = 1'b0;
        slot_period[s] = '0;
        slot_count[s] = '0;
        slot_pending[s] = '0;
      end
      ticks_seen = '0;
      awaited_replies.delete();
    end else begin
      if (in_valid && in_ready) begin
        awaited_replies.push_back(schedule_command(in_op, in_slot, in_period,
                                                   in_enable_flag, in_release_now));
      end
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("unexpected word", 32'd1, 32'd0);
        end else begin
          want = awaited_replies.pop_front();
          if (out_accepted !== want.accepted)
            report_mismatch("accepted", 32'(out_accepted), 32'(want.accepted));
          if (out_dispatched !== want.dispatched)
            report_mismatch("dispatched", 32'(out_dispatched), 32'(want.dispatched));
          if (out_task_slot !== want.task_slot)
            report_mismatch("task_slot", 32'(out_task_slot), 32'(want.task_slot));
          if (out_tick_total !== want.tick_total)
            report_mismatch("tick_total", out_tick_total, want.tick_total);
        end
      end
    end
    replies_outstanding <= awaited_replies.size();
  end

endmodule

@@ verif/periodic_task_release_scheduler_top_test.sv @@
// Testbench top for the task release scheduler: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module periodic_task_release_scheduler_top_test;
  import ptrs_pkg::*;

  localparam int TASK_SLOTS   = 8;
  localparam int PENDING_BITS = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 160;
  localparam int FILL_WORDS   = 320;
  localparam int MIX_WORDS    = 190;

  // op codes the block ignores
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [3:0]  in_slot;
  logic [15:0] in_period;
  logic        in_enable_flag;
  logic        in_release_now;
  logic        out_valid;
  logic        out_ready;
  logic        out_accepted;
  logic        out_dispatched;
  logic [3:0]  out_task_slot;
  logic [31:0] out_tick_total;
  int          fail_count;
  int          replies_outstanding;
  int          cycles = 0;
  bit          no_idle = 1'b0;
  bit          hold_request = 1'b0;

  periodic_task_release_scheduler_top #(
    .TASK_SLOTS  (TASK_SLOTS),
    .PENDING_BITS(PENDING_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_slot       (in_slot),
    .in_period     (in_period),
    .in_enable_flag(in_enable_flag),
    .in_release_now(in_release_now),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_accepted  (out_accepted),
    .out_dispatched(out_dispatched),
    .out_task_slot (out_task_slot),
    .out_tick_total(out_tick_total)
  );

  ptrs_reply_checker #(
    .TASK_SLOTS  (TASK_SLOTS),
    .PENDING_BITS(PENDING_BITS)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_slot            (in_slot),
    .in_period          (in_period),
    .in_enable_flag     (in_enable_flag),
    .in_release_now     (in_release_now),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accepted       (out_accepted),
    .out_dispatched     (out_dispatched),
    .out_task_slot      (out_task_slot),
    .out_tick_total     (out_tick_total),
    .fail_count         (fail_count),
    .replies_outstanding(replies_outstanding)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("periodic_task_release_scheduler_top test failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [3:0] rand_slot();
    if ($urandom_range(7) == 0) return 4'($urandom_range(15, TASK_SLOTS));
    return 4'($urandom_range(TASK_SLOTS - 1, 0));
  endfunction

  function automatic logic [15:0] rand_period();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 16'($urandom_range(6, 1));
    if (roll < 78) return '0;
    if (roll < 84) return '1;
    return 16'($urandom);
  endfunction

  // Offers one command word from a falling edge and returns at a falling edge after acceptance.
  task automatic send_word(logic [2:0] op, logic [3:0] slot, logic [15:0] period,
      logic en, logic rel);
    int gap;
    in_op = op;
    in_slot = slot;
    in_period = period;
    in_enable_flag = en;
    in_release_now = rel;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = no_idle ? 0 : idle_len();
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_mix_word();
    int         roll;
    logic [2:0] op;
    roll = $urandom_range(99);
    if (roll < 28) op = OP_TICK;
    else if (roll < 56) op = OP_DISPATCH;
    else if (roll < 66) op = OP_ADD;
    else if (roll < 74) op = OP_ENABLE;
    else if (roll < 86) op = OP_SET_PERIOD;
    else if (roll < 96) op = OP_RELEASE;
    else op = roll[0] ? OP_SPARE_A : OP_SPARE_B;
    send_word(op, rand_slot(), rand_period(), $urandom_range(3) != 0, 1'($urandom_range(1)));
  endtask

  // stop offering, then wait for every reply
  task automatic drain_replies();
    in_valid = 1'b0;
    while (replies_outstanding != 0) @(negedge clk);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    bit hold_served;
    out_ready = 1'b0;
    hold_served = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_served) begin
        out_ready = 1'b0;
        hold_served = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_ready = 1'b1;
      end else if (no_idle) begin
        out_ready = 1'b1;
      end else begin
        stall = idle_len();
        if (stall != 0) begin
          out_ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    int         roll;
    logic [3:0] noise_slot;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_TICK;
    in_slot = '0;
    in_period = '0;
    in_enable_flag = 1'b0;
    in_release_now = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty table, range checks, not-present slots, disable, ignored ops
    send_word(OP_DISPATCH, 4'd0, 16'h0000, 1'b0, 1'b0);
    send_word(OP_TICK, 4'd15, 16'hFFFF, 1'b1, 1'b1);
    send_word(OP_ADD, 4'd0, 16'h0000, 1'b0, 1'b0);
    send_word(OP_ADD, 4'd7, 16'h0001, 1'b0, 1'b0);
    send_word(OP_ADD, 4'd8, 16'h0005, 1'b1, 1'b0);
    send_word(OP_ADD, 4'd15, 16'hFFFF, 1'b1, 1'b1);
    send_word(OP_RELEASE, 4'd3, 16'h0000, 1'b0, 1'b0);
    send_word(OP_RELEASE, 4'd7, 16'h0000, 1'b0, 1'b0);
    send_word(OP_RELEASE, 4'd12, 16'h0000, 1'b0, 1'b0);
    send_word(OP_ENABLE, 4'd5, 16'h0000, 1'b0, 1'b0);
    send_word(OP_ENABLE, 4'd9, 16'h0000, 1'b1, 1'b0);
    send_word(OP_SET_PERIOD, 4'd2, 16'hFFFF, 1'b0, 1'b1);
    send_word(OP_SET_PERIOD, 4'd10, 16'h0003, 1'b0, 1'b1);
    send_word(OP_TICK, 4'd0, 16'h0000, 1'b0, 1'b0);
    send_word(OP_TICK, 4'd0, 16'h0000, 1'b0, 1'b0);
    send_word(OP_SPARE_A, 4'd1, 16'($urandom), 1'b1, 1'b0);
    send_word(OP_SPARE_B, 4'd15, 16'hFFFF, 1'b1, 1'b1);
    send_word(OP_DISPATCH, 4'd0, 16'h0000, 1'b0, 1'b0);
    send_word(OP_ENABLE, 4'd7, 16'h0000, 1'b0, 1'b0);
    send_word(OP_DISPATCH, 4'd0, 16'h0000, 1'b0, 1'b0);
    send_word(OP_TICK, 4'd0, 16'h0000, 1'b0, 1'b0);
    send_word(OP_ENABLE, 4'd7, 16'h0000, 1'b1, 1'b0);
    send_word(OP_SET_PERIOD, 4'd7, 16'h0002, 1'b0, 1'b0);
    send_word(OP_DISPATCH, 4'd0, 16'h0000, 1'b0, 1'b0);
    send_word(OP_ADD, 4'd2, 16'h0003, 1'b0, 1'b0);

    // fill: slot 7 with period 1 gains a release on nearly every word, so it saturates
    send_word(OP_ADD, 4'd7, 16'h0001, 1'b0, 1'b0);
    send_word(OP_ADD, 4'd6, 16'h0001, 1'b0, 1'b0);
    no_idle = 1'b1;
    hold_request = 1'b1;
    for (int n = 0; n < FILL_WORDS; n++) begin
      if (n == 24) no_idle = 1'b0;
      if (n == FILL_WORDS / 2) drain_replies();
      roll = $urandom_range(99);
      noise_slot = ($urandom_range(3) == 0) ? 4'($urandom_range(15, TASK_SLOTS))
                                             : 4'($urandom_range(TASK_SLOTS - 2, 0));
      if (roll < 50) begin
        send_word(OP_TICK, rand_slot(), rand_period(), 1'($urandom_range(1)), 1'b0);
      end else if (roll < 88) begin
        send_word(OP_RELEASE, 4'd7, rand_period(), 1'b1, 1'($urandom_range(1)));
      end else if (roll < 91) begin
        send_word(OP_DISPATCH, rand_slot(), 16'($urandom), 1'b0, 1'b0);
      end else if (roll < 94) begin
        send_word(OP_RELEASE, noise_slot, 16'($urandom), 1'b0, 1'b1);
      end else if (roll < 97) begin
        send_word(OP_ENABLE, noise_slot, 16'($urandom), 1'($urandom_range(1)), 1'b0);
      end else begin
        send_word(OP_SET_PERIOD, noise_slot, rand_period(), 1'b1, 1'($urandom_range(1)));
      end
    end

    // the sender waits until every reply has come back
    drain_replies();

    // general mix, dispatch-heavy so the saturated counts drain
    for (int n = 0; n < MIX_WORDS; n++) begin
      no_idle = (n >= 60 && n < 100);
      send_mix_word();
    end
    no_idle = 1'b0;

    drain_replies();
    repeat (30) @(negedge clk);
    if (fail_count == 0 && replies_outstanding == 0) begin
      $display("periodic_task_release_scheduler_top test passed");
    end else begin
      $display("periodic_task_release_scheduler_top test failed");
    end
    $finish;
  end

endmodule
